>>> rtl/ldos_pkg.sv
// ldos_pkg: shared constants, payload and control types of the lorentzian dos accumulator
// used by every module of the block; no dependencies
package ldos_pkg;

    localparam int BANDS   = 12;
    localparam int POINTS  = 4;
    localparam int ENTRIES = BANDS * POINTS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;

    localparam logic [30:0] TENTH_Q16  = 31'd6554;
    localparam logic [22:0] INV_PI_Q24 = 23'd5340354;
    localparam logic [30:0] G_MAX      = 31'h7fff_ffff;

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] CFG_WIDTH = 3'd0;
    localparam logic [2:0] CFG_MODE  = 3'd1;
    localparam logic [2:0] CFG_FERMI = 3'd2;
    localparam logic [2:0] CFG_EDGE  = 3'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         point_index;
        logic [3:0]         band_index;
        logic signed [31:0] band_energy;
        logic signed [15:0] band_weight;
        logic signed [31:0] bin_energy;
    } t_in;

    typedef struct packed {
        logic signed [31:0] dos_value;
        logic               saturated;
    } t_out;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_NULLQ = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] band_energy;
        logic signed [15:0] band_weight;
        logic signed [31:0] bin_energy;
    } t_job;

    typedef struct packed {
        logic [30:0]        eta;
        logic               mode;
        logic               fermi;
        logic signed [31:0] edge_e;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/ldos_front.sv
// ldos_front: accepts items, classifies them, drops out-of-range loads and holds the rest in a two-entry job queue
// depends on ldos_pkg
module ldos_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ldos_pkg::t_in   i_data,
    output logic            o_job_valid,
    input  logic            i_job_pop,
    output ldos_pkg::t_job  o_job
);

    ldos_pkg::t_job r_q [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    ldos_pkg::t_job job;
    logic           keep;
    logic           push;
    logic           pop;

    always_comb begin
        job.band_energy = i_data.band_energy;
        job.band_weight = i_data.band_weight;
        job.bin_energy  = i_data.bin_energy;
        job.addr = ldos_pkg::ADDR_W'(32'(i_data.point_index) * ldos_pkg::BANDS
                   + 32'(i_data.band_index));
        keep = 1'b1;
        if (i_data.cmd == ldos_pkg::CMD_LOAD) begin
            job.op = ldos_pkg::OP_LOAD;
            keep = (32'(i_data.point_index) < ldos_pkg::POINTS)
                && (32'(i_data.band_index) < ldos_pkg::BANDS);
        end else if (32'(i_data.point_index) < ldos_pkg::POINTS) begin
            job.op = ldos_pkg::OP_QUERY;
            job.addr = ldos_pkg::ADDR_W'(32'(i_data.point_index) * ldos_pkg::BANDS);
        end else begin
            job.op = ldos_pkg::OP_NULLQ;
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];
    assign push        = i_valid && !o_stall && keep;
    assign pop         = o_job_valid && i_job_pop;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

endmodule

>>> rtl/ldos_div.sv
// ldos_div: shared restoring divider, 64-bit by 64-bit, one quotient bit per cycle
// depends on ldos_pkg
module ldos_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ldos_pkg::t_div_req  i_req,
    output ldos_pkg::t_div_rsp  o_rsp
);

    logic [64:0]                    r_rem;
    logic [63:0]                    r_quo;
    logic [63:0]                    r_den;
    logic [ldos_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [64:0]                    trial;
    logic                           fits;

    assign trial = {r_rem[63:0], r_quo[63]};
    assign fits  = (trial >= {1'b0, r_den});
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[62:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ldos_pkg::DIV_CNT_W'(ldos_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ldos_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/ldos_back.sv
// ldos_back: band table memory and the query sequencer (width, per-band term, sum, scaling)
// depends on ldos_pkg and ldos_div
module ldos_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ldos_pkg::t_cfg  i_cfg,
    input  logic            i_job_valid,
    output logic            o_job_pop,
    input  ldos_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_stall,
    output ldos_pkg::t_out  o_data
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_GMUL   = 14'b00000000000010,
        S_GSTART = 14'b00000000000100,
        S_GDIV   = 14'b00000000001000,
        S_RD     = 14'b00000000010000,
        S_DIFF   = 14'b00000000100000,
        S_SQ1    = 14'b00000001000000,
        S_SQ2    = 14'b00000010000000,
        S_LSTART = 14'b00000100000000,
        S_LDIV   = 14'b00001000000000,
        S_ACC    = 14'b00010000000000,
        S_FIN1   = 14'b00100000000000,
        S_FIN2   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    logic signed [31:0] mem_e [ldos_pkg::ENTRIES];
    logic signed [15:0] mem_w [ldos_pkg::ENTRIES];

    t_state                      r_state;
    logic [ldos_pkg::ADDR_W-1:0] r_base;
    logic [ldos_pkg::BAND_W-1:0] r_j;
    logic signed [31:0]          r_e;
    logic [30:0]                 r_g;
    logic [62:0]                 r_prod;
    logic signed [31:0]          r_eb;
    logic signed [15:0]          r_wb;
    logic [30:0]                 r_ad;
    logic [30:0]                 r_gs;
    logic [1:0]                  r_k;
    logic [61:0]                 r_sq;
    logic [62:0]                 r_den;
    logic [33:0]                 r_q;
    logic signed [55:0]          r_s;
    logic                        r_neg;
    logic [43:0]                 r_lo;
    logic [20:0]                 r_ah;
    logic signed [31:0]          r_res;
    logic                        r_sat;
    logic                        r_ovalid;
    ldos_pkg::t_out              r_odata;

    ldos_pkg::t_div_req          div_req;
    ldos_pkg::t_div_rsp          div_rsp;
    logic [ldos_pkg::ADDR_W-1:0] rd_addr;
    logic [31:0]                 edge_mag;
    logic [31:0]                 e_mag;
    logic signed [32:0]          d;
    logic [32:0]                 ad;
    logic [1:0]                  k;
    logic signed [50:0]          term;
    logic [55:0]                 s_mag;
    logic [41:0]                 s_sh;
    logic [65:0]                 m_full;
    logic [41:0]                 m;
    logic                        load_wr;
    logic                        out_free;

    ldos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign load_wr   = o_job_pop && (i_job.op == ldos_pkg::OP_LOAD);
    assign rd_addr   = ldos_pkg::ADDR_W'(r_base + ldos_pkg::ADDR_W'(r_j));
    assign edge_mag  = i_cfg.edge_e[31] ? 32'(-i_cfg.edge_e) : 32'(i_cfg.edge_e);
    assign e_mag     = r_e[31] ? 32'(-r_e) : 32'(r_e);
    assign out_free  = !r_ovalid || !i_stall;

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = 64'(r_prod);
        div_req.den   = 64'(edge_mag);
        if (r_state == S_GSTART) begin
            div_req.start = 1'b1;
        end else if (r_state == S_LSTART) begin
            div_req.start = (r_den != '0);
            div_req.num   = {1'b0, r_gs, 32'd0};
            div_req.den   = 64'(r_den);
        end
    end

    always_comb begin
        d  = 33'(r_e) - 33'(r_eb);
        ad = d[32] ? 33'(-d) : 33'(d);
        k  = ad[32] ? 2'd2 : (ad[31] ? 2'd1 : 2'd0);
        term   = $signed({1'b0, r_q}) * r_wb;
        s_mag  = r_s[55] ? 56'(-r_s) : 56'(r_s);
        s_sh   = s_mag[55:14];
        m_full = ((66'(r_ah) * 66'(ldos_pkg::INV_PI_Q24)) << 21) + 66'(r_lo);
        m      = m_full[65:24];
    end

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem_e[i_job.addr] <= i_job.band_energy;
            mem_w[i_job.addr] <= i_job.band_weight;
        end
        if (r_state == S_RD) begin
            r_eb <= mem_e[rd_addr];
            r_wb <= mem_w[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_j      <= '0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_base <= i_job.addr;
                    r_e    <= i_job.bin_energy;
                    r_j    <= '0;
                    r_s    <= '0;
                    r_g    <= i_cfg.eta;
                    if (o_job_pop) begin
                        if (i_job.op == ldos_pkg::OP_NULLQ) begin
                            r_res   <= '0;
                            r_sat   <= 1'b0;
                            r_state <= S_OUT;
                        end else if (i_job.op == ldos_pkg::OP_QUERY) begin
                            r_state <= i_cfg.mode ? S_GMUL : S_RD;
                        end
                    end
                end
                S_GMUL: begin
                    r_prod <= 63'(e_mag) * 63'(i_cfg.eta);
                    if (edge_mag == '0) begin
                        r_g     <= ldos_pkg::TENTH_Q16;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_GSTART;
                    end
                end
                S_GSTART: begin
                    r_state <= S_GDIV;
                end
                S_GDIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quo > 64'(ldos_pkg::G_MAX - ldos_pkg::TENTH_Q16)) begin
                            r_g <= ldos_pkg::G_MAX;
                        end else begin
                            r_g <= 31'(div_rsp.quo) + ldos_pkg::TENTH_Q16;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_ad    <= 31'(ad >> k);
                    r_gs    <= r_g >> k;
                    r_k     <= k;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_sq    <= 62'(r_ad) * 62'(r_ad);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_den   <= 63'(r_sq) + 63'(62'(r_gs) * 62'(r_gs));
                    r_state <= S_LSTART;
                end
                S_LSTART: begin
                    if (r_den == '0) begin
                        r_q     <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: begin
                    if (div_rsp.done) begin
                        r_q     <= 34'(div_rsp.quo >> r_k);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_s <= r_s + 56'(term);
                    if (32'(r_j) == ldos_pkg::BANDS - 1) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN1: begin
                    r_neg   <= r_s[55] ^ (i_cfg.fermi && (r_e > 32'sd0));
                    r_lo    <= 44'(s_sh[20:0]) * 44'(ldos_pkg::INV_PI_Q24);
                    r_ah    <= s_sh[41:21];
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    if (r_neg) begin
                        r_sat <= (m > 42'h0_8000_0000);
                        r_res <= (m > 42'h0_8000_0000) ? 32'sh8000_0000 : 32'(-m);
                    end else begin
                        r_sat <= (m > 42'h0_7fff_ffff);
                        r_res <= (m > 42'h0_7fff_ffff) ? 32'sh7fff_ffff : 32'(m);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_odata.dos_value <= r_res;
            r_odata.saturated <= r_sat;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && i_stall) |=> (r_state == S_OUT))
        else $error("result overwrote a waiting output");
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_j) < ldos_pkg::BANDS))
        else $error("band counter out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == S_IDLE))
        else $error("job taken while busy");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == S_GDIV || r_state == S_LDIV))
        else $error("divider started outside a divide step");

endmodule

>>> rtl/lorentzian_dos_accumulator.sv
// lorentzian_dos_accumulator: top level, configuration registers, front queue and back sequencer
// depends on ldos_pkg, ldos_front, ldos_back
// a load item is written to the band table as the back takes it; a query walks the bands in turn
// on the 64-step shared divider; in linear mode a nonzero grid edge adds a division for the width
// the two-entry queue takes items while a query runs; a result waits in the output register
// synchronous active-low reset clears control state; band table contents are undefined until loaded
module lorentzian_dos_accumulator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ldos_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ldos_pkg::t_out  o_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    ldos_pkg::t_cfg r_cfg;
    logic           job_valid;
    logic           job_pop;
    ldos_pkg::t_job job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eta    <= 31'd6554;
            r_cfg.mode   <= 1'b0;
            r_cfg.fermi  <= 1'b0;
            r_cfg.edge_e <= -32'sd655360;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ldos_pkg::CFG_WIDTH: r_cfg.eta    <= i_cfg_data[30:0];
                ldos_pkg::CFG_MODE:  r_cfg.mode   <= i_cfg_data[0];
                ldos_pkg::CFG_FERMI: r_cfg.fermi  <= i_cfg_data[0];
                ldos_pkg::CFG_EDGE:  r_cfg.edge_e <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    ldos_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    ldos_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

>>> sim/ldos_checker.sv
`timescale 1ns / 1ps
// ldos_checker: watches the item, result and register channels of the dos accumulator,
// predicts each query result and compares it with what the block returns
// depends on ldos_pkg
module ldos_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall_in,
    input  ldos_pkg::t_in   i_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  ldos_pkg::t_out  i_out_data,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    import ldos_pkg::*;

    logic signed [31:0] energy_tab [ENTRIES];
    logic signed [15:0] weight_tab [ENTRIES];
    logic [30:0]        eta;
    logic               lin_mode;
    logic               fermi;
    logic signed [31:0] edge_e;
    t_out               dos_queue [$];

    function automatic longint unsigned lorentz_term(longint d, longint unsigned g);
        longint unsigned ad;
        longint unsigned den;
        int k;
        ad = (d < 0) ? longint'(-d) : longint'(d);
        k = 0;
        while (k < 2 && (ad >> k) >= 64'h8000_0000) k++;
        ad = ad >> k;
        g = g >> k;
        den = ad * ad + g * g;
        if (den == 0) return 0;
        return ((g << 32) / den) >> k;
    endfunction

    function automatic t_out dos_at(int pt, logic signed [31:0] e_in);
        t_out r;
        longint e, s, ge;
        longint unsigned g, rr, m, as;
        logic neg;
        e = e_in;
        if (lin_mode) begin
            ge = (edge_e < 0) ? -longint'(edge_e) : longint'(edge_e);
            rr = (ge == 0) ? 0 : ((e < 0 ? -e : e) * longint'(eta)) / ge;
            g = (rr > 64'(G_MAX) - 64'(TENTH_Q16)) ? 64'(G_MAX) : rr + 64'(TENTH_Q16);
        end else begin
            g = eta;
        end
        s = 0;
        for (int j = 0; j < BANDS; j++) begin
            s += longint'(lorentz_term(e - longint'(energy_tab[pt * BANDS + j]), g))
                 * longint'(weight_tab[pt * BANDS + j]);
        end
        neg = s < 0;
        if (fermi && e > 0) neg = !neg;
        as = (s < 0) ? longint'(-s) : longint'(s);
        m = ((as >> 14) * 64'(INV_PI_Q24)) >> 24;
        r.saturated = 1'b0;
        if (neg) begin
            if (m > 64'h8000_0000) begin
                m = 64'h8000_0000;
                r.saturated = 1'b1;
            end
            r.dos_value = 32'(-longint'(m));
        end else begin
            if (m > 64'h7fff_ffff) begin
                m = 64'h7fff_ffff;
                r.saturated = 1'b1;
            end
            r.dos_value = 32'(m);
        end
        return r;
    endfunction

    assign o_pending = dos_queue.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            eta <= TENTH_Q16;
            lin_mode <= 1'b0;
            fermi <= 1'b0;
            edge_e <= -32'sd655360;
            o_fail_count <= 0;
            dos_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH: eta <= i_cfg_data[30:0];
                    CFG_MODE:  lin_mode <= i_cfg_data[0];
                    CFG_FERMI: fermi <= i_cfg_data[0];
                    CFG_EDGE:  edge_e <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (i_data.cmd == CMD_LOAD) begin
                    if (i_data.band_index < BANDS) begin
                        energy_tab[i_data.point_index * BANDS + i_data.band_index] =
                            i_data.band_energy;
                        weight_tab[i_data.point_index * BANDS + i_data.band_index] =
                            i_data.band_weight;
                    end
                end else begin
                    dos_queue.push_back(dos_at(i_data.point_index, i_data.bin_energy));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (dos_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result dos=%0d sat=%0d",
                                 i_out_data.dos_value, i_out_data.saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = dos_queue.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch dos exp=%0d got=%0d sat exp=%0d got=%0d",
                                     want.dos_value, i_out_data.dos_value,
                                     want.saturated, i_out_data.saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/tb_lorentzian_dos_accumulator.sv
`timescale 1ns / 1ps
// tb_lorentzian_dos_accumulator: stimulus, register setup and verdict for the dos accumulator
// depends on ldos_pkg, lorentzian_dos_accumulator and ldos_checker
module tb_lorentzian_dos_accumulator;
    import ldos_pkg::*;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    t_in            i_data;
    logic           o_valid;
    logic           i_stall;
    t_out           o_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [31:0]    i_cfg_data;
    int             fail_count;
    int             pending;
    int             idle_cycles;
    int             stall_mode;
    int             stall_timer;
    logic [BANDS-1:0]   loaded [POINTS];
    logic signed [31:0] band_copy [ENTRIES];

    lorentzian_dos_accumulator u_top (.*);

    ldos_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall pattern: never, half the time or mostly stalled, chosen anew when the stall timer runs out
    always @(negedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(50, 400);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= $urandom_range(0, 1);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 50000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(t_in it);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        if (it.cmd == CMD_LOAD && it.band_index < BANDS) begin
            loaded[it.point_index][it.band_index] = 1'b1;
            band_copy[it.point_index * BANDS + it.band_index] = it.band_energy;
        end
    endtask

    task automatic load_band(int pt, int band, logic signed [31:0] en, logic signed [15:0] w);
        t_in it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.point_index = pt;
        it.band_index = band;
        it.band_energy = en;
        it.band_weight = w;
        it.bin_energy = $urandom;
        send_item(it);
    endtask

    task automatic query_dos(int pt, logic signed [31:0] en);
        t_in it;
        it = '0;
        it.cmd = CMD_QUERY;
        it.point_index = pt;
        it.band_index = $urandom;
        it.band_energy = $urandom;
        it.band_weight = $urandom;
        it.bin_energy = en;
        send_item(it);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [30:0] w, logic m, logic f, logic signed [31:0] ge);
        write_reg(CFG_WIDTH, {1'b0, w});
        write_reg(CFG_MODE, {31'd0, m});
        write_reg(CFG_FERMI, {31'd0, f});
        write_reg(CFG_EDGE, ge);
    endtask

    task automatic random_item;
        t_in it;
        int pt;
        logic signed [31:0] base;
        it = '0;
        it.cmd = CMD_QUERY;
        if ($urandom_range(0, 99) < 45) it.cmd = CMD_LOAD;
        pt = $urandom_range(0, POINTS - 1);
        if (it.cmd == CMD_QUERY) begin
            do pt = $urandom_range(0, POINTS - 1); while (loaded[pt] != '1);
        end
        it.point_index = pt;
        it.band_index = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, BANDS - 1);
        it.band_energy = ($urandom_range(0, 3) == 0) ? $urandom
                                                     : $signed($urandom_range(0, 524288)) - 262144;
        it.band_weight = $urandom;
        base = band_copy[pt * BANDS + $urandom_range(0, BANDS - 1)];
        case ($urandom_range(0, 9))
            0, 1:    it.bin_energy = $urandom;
            2, 3, 4: it.bin_energy = $signed($urandom_range(0, 524288)) - 262144;
            default: it.bin_energy = base + $signed($urandom_range(0, 32768)) - 16384;
        endcase
        send_item(it);
    endtask

    initial begin
        logic [30:0] w;
        logic signed [31:0] ge;
        int burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        stall_mode = 0;
        stall_timer = 0;
        idle_cycles = 0;
        for (int p = 0; p < POINTS; p++) loaded[p] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // field extremes, ignored loads and queries under the reset settings
        load_band(0, 0, 32'sh7fff_ffff, 16'sh7fff);
        load_band(0, 1, 32'sh8000_0000, 16'sh8000);
        for (int b = 2; b < BANDS; b++)
            load_band(0, b, $signed($urandom_range(0, 131072)) - 65536, $urandom);
        load_band(0, 12, 32'sd0, 16'sh7fff);
        load_band(3, 15, 32'sd0, 16'sh7fff);
        query_dos(0, 32'sd0);
        query_dos(0, 32'sh7fff_ffff);
        query_dos(0, 32'sh8000_0000);
        query_dos(0, band_copy[2]);
        drain();

        // narrow width on uniform weights saturates, fermi flips the sign, then width and edge extremes
        set_regs(31'd1, 1'b0, 1'b1, -32'sd655360);
        for (int b = 0; b < BANDS; b++) load_band(1, b, 32'sd0, 16'sh7fff);
        query_dos(1, 32'sd0);
        query_dos(1, 32'sd1);
        drain();
        set_regs(31'd0, 1'b0, 1'b0, -32'sd655360);
        query_dos(0, band_copy[2]);
        drain();
        set_regs(31'h7fff_ffff, 1'b1, 1'b0, 32'sd0);
        query_dos(0, 32'sh4000_0000);
        drain();
        set_regs(31'h7fff_ffff, 1'b1, 1'b1, 32'sh8000_0000);
        query_dos(1, 32'sh8000_0000);
        query_dos(1, 32'sh7fff_ffff);
        drain();
        set_regs(31'd3, 1'b1, 1'b0, 32'sd1);
        write_reg(3'd5, $urandom);
        query_dos(1, 32'sh7fff_ffff);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 4))
                0: w = 31'h7fff_ffff;
                1: w = $urandom_range(0, 3);
                2: w = $urandom;
                default: w = $urandom_range(0, 1 << 18);
            endcase
            case ($urandom_range(0, 4))
                0: ge = 32'sd0;
                1: ge = ($urandom_range(0, 1)) ? 32'sh8000_0000 : 32'sh7fff_ffff;
                2: ge = $urandom;
                default: ge = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            endcase
            set_regs(w, $urandom_range(0, 1), $urandom_range(0, 1), ge);
            for (int n = 0; n < 200; ) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && n < 200; k++, n++) random_item();
                if ($urandom_range(0, 3) != 0) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    repeat ($urandom_range(0, 12)) @(negedge i_clk);
                end
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/ldos_pkg.sv
rtl/ldos_front.sv
rtl/ldos_div.sv
rtl/ldos_back.sv
rtl/lorentzian_dos_accumulator.sv
sim/ldos_checker.sv
sim/tb_lorentzian_dos_accumulator.sv
